### rtl/crf_pkg.sv
// shared types and constants of the clause redundancy filter
package crf_pkg;

   localparam int VAR_ID_WIDTH = 16;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_INS,
      S_FIN,
      S_MARK,
      S_EMIT
   } crf_state_type;

   typedef struct packed {
      logic hit;
      logic opposite;
   } crf_cmp_type;

endpackage

### rtl/crf_if.sv
// valid/ready channel interfaces for literal words and result words
interface crf_req_if;
   import crf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [VAR_ID_WIDTH-1:0] var_id;
   logic                    negated;
   logic                    last_literal;
   logic                    empty_clause;

   modport source (output valid, var_id, negated, last_literal, empty_clause, input ready);
   modport sink (input valid, var_id, negated, last_literal, empty_clause, output ready);
endinterface

interface crf_rsp_if;
   import crf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [VAR_ID_WIDTH-1:0] out_var_id;
   logic                    out_negated;
   logic                    literal_valid;
   logic                    clause_dropped;
   logic                    clause_changed;
   logic                    overflow;
   logic                    last_result;

   modport source (output valid, out_var_id, out_negated, literal_valid, clause_dropped,
                   clause_changed, overflow, last_result, input ready);
   modport sink (input valid, out_var_id, out_negated, literal_valid, clause_dropped,
                 clause_changed, overflow, last_result, output ready);
endinterface

### rtl/crf_ram.sv
// generic single write port ram with registered read
module crf_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/crf_cmp.sv
// shared literal compare unit: same variable and opposite sign detection
module crf_cmp
   import crf_pkg::*;
#(
   parameter int ID_W = 16
) (
   input  logic [ID_W:0] kept_lit,
   input  logic [ID_W:0] new_lit,
   output crf_cmp_type   result
);

   always_comb begin
      result.hit      = (kept_lit[ID_W-1:0] == new_lit[ID_W-1:0]);
      result.opposite = (kept_lit[ID_W] != new_lit[ID_W]);
   end

endmodule

### rtl/clause_redundancy_filter.sv
// clause redundancy filter top level: sequencer, literal store and result register
// usage
//   req channel takes one literal word per clause literal, last_literal on the
//   final one, or a single word with empty_clause set for an empty clause
//   rsp channel gives the kept literals of a finished clause in arrival order,
//   or one dropped marker for a tautology, or one empty marker
// timing
//   each literal word is compared against the kept literals one entry per
//   cycle through the single compare unit and the store's read port:
//   a literal is scanned over the kept literals (at most MAX_LITERALS),
//   stored if none matched, then finished; a literal after a tautology or an
//   empty clause word skips the scan, and the clause closes with the marker
//   emitting a clause reads each kept literal in turn through the store read
//   port, started after the last literal's compare; req.ready is low meanwhile
// reset
//   synchronous; clears the clause flags and count, no words are pending
//   the store needs no clearing, only entries below the count are read
// stall
//   a result word waits in the output register until taken; emission pauses
//   and resumes with no loss
module clause_redundancy_filter
   import crf_pkg::*;
#(
   parameter int MAX_LITERALS = 16,
   parameter int VAR_ID_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   crf_req_if.sink   req,
   crf_rsp_if.source rsp
);

   localparam int ID_W  = (VAR_ID_BITS < VAR_ID_WIDTH) ? VAR_ID_BITS : VAR_ID_WIDTH;
   localparam int IDX_W = $clog2(MAX_LITERALS);
   localparam int CNT_W = $clog2(MAX_LITERALS + 1);

   crf_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             taut_ff, taut_in;
   logic             chg_ff, chg_in;
   logic             ovf_ff, ovf_in;
   logic             mark_drop_ff, mark_drop_in;
   logic [ID_W:0]    lit_ff, lit_in;
   logic             last_ff, last_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAR_ID_WIDTH-1:0] rsp_var_ff, rsp_var_in;
   logic                    rsp_neg_ff, rsp_neg_in;
   logic                    rsp_litv_ff, rsp_litv_in;
   logic                    rsp_drop_ff, rsp_drop_in;
   logic                    rsp_chg_ff, rsp_chg_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic             wr_en;
   logic [ID_W:0]    rd_data;
   crf_cmp_type      cmp;
   logic [CNT_W-1:0] idx_inc;
   logic             full;
   logic             load_ok;
   logic             accept;

   crf_ram #(
      .WIDTH (ID_W + 1),
      .DEPTH (MAX_LITERALS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (lit_ff),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   crf_cmp #(
      .ID_W (ID_W)
   ) u_cmp (
      .kept_lit (rd_data),
      .new_lit  (lit_ff),
      .result   (cmp)
   );

   assign accept  = req.valid && req.ready;
   assign idx_inc = CNT_W'(idx_ff) + CNT_W'(1);
   assign full    = (cnt_ff == CNT_W'(MAX_LITERALS));
   assign load_ok = !rsp_valid_ff || rsp.ready;

   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_var_id     = rsp_var_ff;
   assign rsp.out_negated    = rsp_neg_ff;
   assign rsp.literal_valid  = rsp_litv_ff;
   assign rsp.clause_dropped = rsp_drop_ff;
   assign rsp.clause_changed = rsp_chg_ff;
   assign rsp.overflow       = rsp_ovf_ff;
   assign rsp.last_result    = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         taut_ff      <= 1'b0;
         chg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         taut_ff      <= taut_in;
         chg_ff       <= chg_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mark_drop_ff <= mark_drop_in;
      lit_ff       <= lit_in;
      last_ff      <= last_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_neg_ff   <= rsp_neg_in;
      rsp_litv_ff  <= rsp_litv_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_chg_ff   <= rsp_chg_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      taut_in      = taut_ff;
      chg_in       = chg_ff;
      ovf_in       = ovf_ff;
      mark_drop_in = mark_drop_ff;
      lit_in       = lit_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_var_in   = rsp_var_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_litv_in  = rsp_litv_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lit_in  = {req.negated, req.var_id[ID_W-1:0]};
               last_in = req.last_literal;
               if (req.empty_clause) begin
                  cnt_in       = '0;
                  taut_in      = 1'b0;
                  chg_in       = 1'b0;
                  ovf_in       = 1'b0;
                  mark_drop_in = 1'b0;
                  state_in     = S_MARK;
               end else if (taut_ff) begin
                  if (req.last_literal) begin
                     mark_drop_in = 1'b1;
                     state_in     = S_MARK;
                  end
               end else if (cnt_ff == '0) begin
                  state_in = S_INS;
               end else begin
                  idx_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cmp.hit) begin
               chg_in = 1'b1;
               if (cmp.opposite) begin
                  taut_in = 1'b1;
               end
               state_in = S_FIN;
            end else if (idx_inc == cnt_ff) begin
               state_in = S_INS;
            end else begin
               idx_in = idx_inc[IDX_W-1:0];
            end
         end
         S_INS: begin
            if (full) begin
               ovf_in = 1'b1;
               chg_in = 1'b1;
            end else begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (last_ff) begin
               if (taut_ff || (cnt_ff == '0)) begin
                  mark_drop_in = 1'b1;
                  state_in     = S_MARK;
               end else begin
                  idx_in   = '0;
                  state_in = S_EMIT;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_var_in   = '0;
               rsp_neg_in   = 1'b0;
               rsp_litv_in  = 1'b0;
               rsp_drop_in  = mark_drop_ff;
               rsp_chg_in   = mark_drop_ff;
               rsp_ovf_in   = mark_drop_ff && ovf_ff;
               rsp_last_in  = 1'b1;
               cnt_in       = '0;
               taut_in      = 1'b0;
               chg_in       = 1'b0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_var_in   = VAR_ID_WIDTH'(rd_data[ID_W-1:0]);
               rsp_neg_in   = rd_data[ID_W];
               rsp_litv_in  = 1'b1;
               rsp_drop_in  = 1'b0;
               rsp_chg_in   = chg_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = (idx_inc == cnt_ff);
               idx_in       = idx_inc[IDX_W-1:0];
               if (idx_inc == cnt_ff) begin
                  idx_in   = idx_ff;
                  cnt_in   = '0;
                  taut_in  = 1'b0;
                  chg_in   = 1'b0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/crf_checker.sv
// port level checks of the clause redundancy filter and their bind
module crf_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic literal_valid,
   input logic clause_dropped,
   input logic clause_changed,
   input logic last_result
);

   // result word held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   // flags of a waiting result word do not move
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({literal_valid, clause_dropped, clause_changed, last_result}))
      else $error("result word changed while it waited");

   // markers are single words closing their clause
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !literal_valid |-> last_result)
      else $error("marker word without last_result");

   // dropped clause is a marker and a change
   a_drop_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clause_dropped |-> !literal_valid && clause_changed)
      else $error("dropped flag on a literal word or without change flag");

endmodule

bind clause_redundancy_filter crf_checker u_crf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .literal_valid  (rsp.literal_valid),
   .clause_dropped (rsp.clause_dropped),
   .clause_changed (rsp.clause_changed),
   .last_result    (rsp.last_result)
);
